// ===== src/cur_pkg.sv =====
// ---------------------------------------------------------------------------
// cur_pkg
// Shared types and constants of the consecutive unique runs block.
// ---------------------------------------------------------------------------
package cur_pkg;

   // field widths
   localparam int ELEM_W     = 64;
   localparam int KIND_W     = 2;
   localparam int INDEX_W    = 32;
   localparam int COUNT_OUT_W = 32;
   localparam int LEN_W      = 6;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 6;

   // rsp_tdata: out_value, unique_index, run_count, tensor_done, zero fill
   localparam int RSP_DATA_W = 136;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_INDEX = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SLICE_LEN   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_EMIT_INDEX  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_EMIT_COUNTS = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic check;
      logic close_run;
      logic emit_count;
      logic emit_value;
      logic emit_index;
      logic finish;
   } cur_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slice_end;
      logic is_new;
      logic first;
      logic last;
      logic val_last;
      logic emit_index_en;
      logic emit_counts_en;
      logic out_free;
   } cur_status_type;

endpackage

// ===== src/cur_ram.sv =====
// ---------------------------------------------------------------------------
// cur_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cur_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cur_ctrl.sv =====
// ---------------------------------------------------------------------------
// cur_ctrl
// Sequencer: takes one element, checks it, and at a slice end walks through
// the count, value (new slice only), index and final count results.
// ---------------------------------------------------------------------------
module cur_ctrl
   import cur_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  cur_status_type status,
   output cur_cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_CMP  = 7'b0000010,
      S_CNT1 = 7'b0000100,
      S_RD   = 7'b0001000,
      S_VAL  = 7'b0010000,
      S_IDX  = 7'b0100000,
      S_CNT2 = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      want_cnt1;
   logic      want_cnt2;

   assign want_cnt1 = status.is_new && !status.first && status.emit_counts_en;
   assign want_cnt2 = status.last && status.emit_counts_en;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
            if (req_tvalid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.check = 1'b1;
            state_in  = status.slice_end ? S_CNT1 : S_IDLE;
         end
         S_CNT1: begin
            if (!want_cnt1 || status.out_free) begin
               cmd.emit_count = want_cnt1;
               cmd.close_run  = 1'b1;
               state_in       = status.is_new ? S_RD : S_IDX;
            end
         end
         S_RD: begin
            // read data of the current slice shows up next cycle
            state_in = S_VAL;
         end
         S_VAL: begin
            if (status.out_free) begin
               cmd.emit_value = 1'b1;
               state_in       = status.val_last ? S_IDX : S_RD;
            end
         end
         S_IDX: begin
            if (!status.emit_index_en || status.out_free) begin
               cmd.emit_index = status.emit_index_en;
               state_in       = S_CNT2;
            end
         end
         S_CNT2: begin
            if (!want_cnt2 || status.out_free) begin
               cmd.emit_count = want_cnt2;
               cmd.finish     = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   // a value waiting on a full output register stays put
   a_val_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VAL && !status.out_free) |=> state_ff == S_VAL)
      else $error("value emission left before output register was free");
`endif

endmodule

// ===== src/cur_dp.sv =====
// ---------------------------------------------------------------------------
// cur_dp
// Datapath: configuration registers, slice buffers, compare, run and index
// counters, and the output register.
// ---------------------------------------------------------------------------
module cur_dp
   import cur_pkg::*;
#(
   parameter int MAX_SLICE   = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [ELEM_W-1:0]     req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast,
   input  cur_cmd_type           cmd,
   output cur_status_type        status
);

   localparam int PW = (MAX_SLICE > 1) ? $clog2(MAX_SLICE) : 1;

   // configuration
   logic [LEN_W-1:0] slice_len_ff, slice_len_in;
   logic             emit_index_ff, emit_index_in;
   logic             emit_counts_ff, emit_counts_in;

   // slice state
   logic [ELEM_W-1:0]      value_ff, value_in;
   logic                   last_ff, last_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic                   differs_ff, differs_in;
   logic                   first_ff, first_in;
   logic                   is_new_ff, is_new_in;
   logic [LEN_W-1:0]       n_ff, n_in;
   logic [PW-1:0]          idx_ff, idx_in;
   logic [INDEX_W-1:0]     unique_ff, unique_in;
   logic [COUNT_WIDTH-1:0] run_ff, run_in;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]      out_kind_ff, out_kind_in;
   logic [ELEM_W-1:0]      out_value_ff, out_value_in;
   logic [INDEX_W-1:0]     out_index_ff, out_index_in;
   logic [COUNT_OUT_W-1:0] out_count_ff, out_count_in;
   logic                   out_lor_ff, out_lor_in;
   logic                   out_done_ff, out_done_in;

   logic [ELEM_W-1:0] kept_rd;
   logic [ELEM_W-1:0] cur_rd;
   logic [LEN_W-1:0]  len_eff;
   logic [LEN_W-1:0]  n_now;
   logic              diff_now;
   logic              slice_end;
   logic              val_last;
   logic              out_free;
   logic              emit_any;
   logic              lor_now;

   cur_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_SLICE)) u_cur_ram (
      .clock   (clock),
      .wr_en   (cmd.load_item),
      .wr_addr (pos_ff),
      .wr_data (req_tdata),
      .rd_addr (idx_ff),
      .rd_data (cur_rd)
   );

   // copied from the current slice while its values go out
   cur_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_SLICE)) u_kept_ram (
      .clock   (clock),
      .wr_en   (cmd.emit_value),
      .wr_addr (idx_ff),
      .wr_data (cur_rd),
      .rd_addr (pos_ff),
      .rd_data (kept_rd)
   );

   always_comb begin
      if (slice_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (slice_len_ff > LEN_W'(MAX_SLICE)) begin
         len_eff = LEN_W'(MAX_SLICE);
      end else begin
         len_eff = slice_len_ff;
      end
   end

   assign n_now     = LEN_W'(pos_ff) + LEN_W'(1);
   assign diff_now  = differs_ff || (!first_ff && (kept_rd != value_ff));
   assign slice_end = last_ff || (n_now >= len_eff);
   assign val_last  = (LEN_W'(idx_ff) + LEN_W'(1)) == n_ff;
   assign out_free  = !out_valid_ff || rsp_tready;
   assign emit_any  = cmd.emit_count || cmd.emit_value || cmd.emit_index;

   always_comb begin
      status.slice_end      = slice_end;
      status.is_new         = is_new_ff;
      status.first          = first_ff;
      status.last           = last_ff;
      status.val_last       = val_last;
      status.emit_index_en  = emit_index_ff;
      status.emit_counts_en = emit_counts_ff;
      status.out_free       = out_free;
   end

   always_comb begin
      slice_len_in   = slice_len_ff;
      emit_index_in  = emit_index_ff;
      emit_counts_in = emit_counts_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SLICE_LEN:   slice_len_in   = csr_wdata;
            CSR_EMIT_INDEX:  emit_index_in  = csr_wdata[0];
            CSR_EMIT_COUNTS: emit_counts_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      value_in   = value_ff;
      last_in    = last_ff;
      pos_in     = pos_ff;
      differs_in = differs_ff;
      first_in   = first_ff;
      is_new_in  = is_new_ff;
      n_in       = n_ff;
      idx_in     = idx_ff;
      unique_in  = unique_ff;
      run_in     = run_ff;

      if (cmd.load_item) begin
         value_in = req_tdata;
         last_in  = req_tlast;
      end
      if (cmd.check) begin
         differs_in = diff_now;
         if (slice_end) begin
            is_new_in = first_ff || diff_now;
            n_in      = n_now;
            idx_in    = '0;
         end else begin
            pos_in = PW'(n_now);
         end
      end
      if (cmd.close_run) begin
         if (is_new_ff) begin
            if (!first_ff) begin
               unique_in = unique_ff + INDEX_W'(1);
            end
            run_in = COUNT_WIDTH'(1);
         end else if (run_ff != '1) begin
            run_in = run_ff + COUNT_WIDTH'(1);
         end
      end
      if (cmd.emit_value) begin
         idx_in = idx_ff + PW'(1);
      end
      if (cmd.finish) begin
         first_in   = 1'b0;
         differs_in = 1'b0;
         pos_in     = '0;
         if (last_ff) begin
            first_in  = 1'b1;
            unique_in = '0;
            run_in    = '0;
         end
      end
   end

   // last result of this item: the closing count, or index/value when
   // nothing follows them
   always_comb begin
      if (cmd.emit_count) begin
         lor_now = cmd.finish;
      end else if (cmd.emit_value) begin
         lor_now = val_last && !emit_index_ff && !(last_ff && emit_counts_ff);
      end else begin
         lor_now = !(last_ff && emit_counts_ff);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_index_in = out_index_ff;
      out_count_in = out_count_ff;
      out_lor_in   = out_lor_ff;
      out_done_in  = out_done_ff;
      if (emit_any) begin
         out_valid_in = 1'b1;
         out_value_in = cmd.emit_value ? cur_rd : '0;
         out_index_in = cmd.emit_index ? unique_ff : '0;
         out_count_in = cmd.emit_count ? COUNT_OUT_W'(run_ff) : '0;
         out_lor_in   = lor_now;
         out_done_in  = lor_now && last_ff;
         if (cmd.emit_count) begin
            out_kind_in = KIND_COUNT;
         end else if (cmd.emit_value) begin
            out_kind_in = KIND_VALUE;
         end else begin
            out_kind_in = KIND_INDEX;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_len_ff   <= LEN_W'(1);
         emit_index_ff  <= 1'b1;
         emit_counts_ff <= 1'b1;
         pos_ff         <= '0;
         differs_ff     <= 1'b0;
         first_ff       <= 1'b1;
         unique_ff      <= '0;
         run_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         slice_len_ff   <= slice_len_in;
         emit_index_ff  <= emit_index_in;
         emit_counts_ff <= emit_counts_in;
         pos_ff         <= pos_in;
         differs_ff     <= differs_in;
         first_ff       <= first_in;
         unique_ff      <= unique_in;
         run_ff         <= run_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      last_ff      <= last_in;
      is_new_ff    <= is_new_in;
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_count_ff <= out_count_in;
      out_lor_ff   <= out_lor_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_lor_ff;
   assign rsp_tdata  = {7'd0, out_done_ff, out_count_ff, out_index_ff, out_value_ff};

`ifndef ASSERT_OFF
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_any |-> out_free)
      else $error("result emitted while output register still full");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.close_run |=> run_ff != '0)
      else $error("run length zero after a slice closed");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_done_ff) |-> out_lor_ff)
      else $error("tensor end flagged on a result that is not the item's last");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(pos_ff) < LEN_W'(MAX_SLICE))
      else $error("slice position beyond buffer depth");
`endif

endmodule

// ===== src/consecutive_unique_runs.sv =====
// The first result of a slice end passes S_CMP, S_CNT1 and the output register
// when the closing run count leads; an index also passes S_IDX, a value S_RD, S_VAL.
// An element is taken in S_IDLE and checked in S_CMP before the next is taken; a
// slice end adds S_CNT1, S_RD/S_VAL per value of a new slice, S_IDX and S_CNT2.
// Reset: slice_len 1, index and count results on, a fresh tensor; the slice
// buffers are not cleared.
// ---------------------------------------------------------------------------
// consecutive_unique_runs
// Run-length unique-consecutive over slices of a streamed tensor.
// ---------------------------------------------------------------------------
module consecutive_unique_runs
   import cur_pkg::*;
#(
   parameter int MAX_SLICE   = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ELEM_W-1:0]     req_tdata,   // elem_value
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_value, unique_index, run_count, tensor_done, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]     rsp_tuser,   // result_kind
   output logic                  rsp_tlast
);

   cur_cmd_type    cmd;
   cur_status_type status;

   cur_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cur_dp #(
      .MAX_SLICE   (MAX_SLICE),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
